// ----- hdl/llh_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// llh_pkg
// Shared types and constants of the log luminance histogram.
// ----------------------------------------------------------------------------
package llh_pkg;

   // default sizes
   localparam int unsigned HIST_DEPTH_DEF     = 256;
   localparam int unsigned LOG_TABLE_BITS_DEF = 10;

   // fixed field widths
   localparam int unsigned LUM_W      = 32;
   localparam int unsigned BOUND_W    = 31;
   localparam int unsigned LOG_W      = 24;   // signed Q8.16
   localparam int unsigned LOG_FRAC_W = 16;
   localparam int unsigned EXP_W      = 8;
   localparam int unsigned SCALE_W    = 32;
   localparam int unsigned BINCNT_W   = 9;
   localparam int unsigned COUNT_W    = 32;
   localparam int unsigned HIT_W      = 8;
   localparam int unsigned CMD_W      = 2;
   localparam int unsigned CSR_IDX_W  = 3;
   localparam int unsigned CSR_DATA_W = 32;
   localparam int unsigned SQ_W       = 31;   // squaring operand, Q1.30 after normalize
   localparam int unsigned STEP_W     = 4;    // indexes the 16 fraction bits

   // register map
   localparam logic [CSR_IDX_W-1:0] CSR_LUM_MIN   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LUM_MAX   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LOG_FLOOR = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_BIN_SCALE = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_BIN_COUNT = 3'd4;

   // register reset values
   localparam logic [BOUND_W-1:0]  LUM_MIN_RST   = 31'h0000_0000;
   localparam logic [BOUND_W-1:0]  LUM_MAX_RST   = 31'h7F7F_FFFF;
   localparam logic [LOG_W-1:0]    LOG_FLOOR_RST = 24'h00_0000;
   localparam logic [SCALE_W-1:0]  BIN_SCALE_RST = 32'h0001_0000;
   localparam logic [BINCNT_W-1:0] BIN_COUNT_RST = 9'd256;

   localparam logic [EXP_W-1:0]   EXP_BIAS  = 8'd127;
   localparam logic [EXP_W-1:0]   EXP_SPECIAL = 8'hFF;
   localparam logic [COUNT_W-1:0] COUNT_MAX = 32'hFFFF_FFFF;

   typedef enum logic [CMD_W-1:0] {
      CMD_ADD   = 2'd0,
      CMD_READ  = 2'd1,
      CMD_CLEAR = 2'd2
   } llh_cmd_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOG,
      ST_SCALE,
      ST_MULT,
      ST_CLAMP,
      ST_FETCH,
      ST_UPDATE,
      ST_REPLY
   } llh_state_type;

   function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
      sat_inc = (v == COUNT_MAX) ? v : v + COUNT_W'(1);
   endfunction

endpackage

// ----- hdl/log_luminance_histogram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// log_luminance_histogram
// Histogram of pixel luminance on a log2 axis, bins kept in one RAM.
// ----------------------------------------------------------------------------
//
//  channel | ports                                          | dir
//  --------+------------------------------------------------+-----
//  req     | req_valid req_stall req_cmd req_luminance      | in
//          | req_bin_index                                  |
//  rsp     | rsp_valid rsp_stall rsp_counted rsp_bin_hit    | out
//          | rsp_bin_value rsp_total_count                  |
//  csr     | csr_we csr_index csr_wdata                     | in
//
//  Steps per beat, accept to accept: an add sample runs sixteen squaring
//  rounds on one shared 31x31 multiplier, then scale, clamp, RAM read and
//  write back; a read fetches its bin; a rejected sample, an out-of-range read
//  or an unused command goes straight to the reply; a clear zeroes every bin.
//  After reset the bin RAM is swept to zero; req_stall stays high
//  meanwhile, csr writes are taken as usual.
//  One item is in flight at a time. The rsp register lets the next req beat
//  be accepted while a result waits on rsp_stall.
//
module log_luminance_histogram
   import llh_pkg::*;
#(
   parameter int unsigned HIST_DEPTH     = HIST_DEPTH_DEF,
   parameter int unsigned LOG_TABLE_BITS = LOG_TABLE_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   // request beats
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [CMD_W-1:0]      req_cmd,
   input  logic [LUM_W-1:0]      req_luminance,
   input  logic [HIT_W-1:0]      req_bin_index,
   // response beats
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic                  rsp_counted,
   output logic [HIT_W-1:0]      rsp_bin_hit,
   output logic [COUNT_W-1:0]    rsp_bin_value,
   output logic [COUNT_W-1:0]    rsp_total_count,
   // register writes
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int unsigned BIN_W = $clog2(HIST_DEPTH);
   localparam int unsigned IDX_W = (BIN_W > HIT_W) ? BIN_W : HIT_W;
   localparam int unsigned PROD_SQ_W = 2 * SQ_W;
   localparam int unsigned PROD_BIN_W = LOG_W + SCALE_W;

   // ---------------------------------------------------------------------
   // registers
   // ---------------------------------------------------------------------
   llh_state_type       state_ff, state_in;
   logic [BIN_W-1:0]    sweep_ff, sweep_in;
   logic                reply_ff, reply_in;     // clear command waits for a reply
   llh_cmd_type         op_ff, op_in;
   logic [SQ_W-1:0]     x_ff, x_in;
   logic [STEP_W-1:0]   k_ff, k_in;
   logic [EXP_W-1:0]    e_ff, e_in;
   logic [LOG_FRAC_W-1:0] r_ff, r_in;
   logic [LOG_W-1:0]    d_ff, d_in;
   logic [LOG_W-1:0]    bin_raw_ff, bin_raw_in;
   logic [BIN_W-1:0]    addr_ff, addr_in;
   logic [COUNT_W-1:0]  total_ff, total_in;
   logic                res_counted_ff, res_counted_in;
   logic [HIT_W-1:0]    res_hit_ff, res_hit_in;
   logic [COUNT_W-1:0]  res_value_ff, res_value_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_counted_ff, rsp_counted_in;
   logic [HIT_W-1:0]    rsp_hit_ff, rsp_hit_in;
   logic [COUNT_W-1:0]  rsp_value_ff, rsp_value_in;
   logic [COUNT_W-1:0]  rsp_total_ff, rsp_total_in;

   logic [BOUND_W-1:0]  lum_min_ff;
   logic [BOUND_W-1:0]  lum_max_ff;
   logic [LOG_W-1:0]    log_floor_ff;
   logic [SCALE_W-1:0]  bin_scale_ff;
   logic [BINCNT_W-1:0] bin_count_ff;

   // ---------------------------------------------------------------------
   // RAM
   // ---------------------------------------------------------------------
   logic               ram_we;
   logic [BIN_W-1:0]   ram_waddr;
   logic [COUNT_W-1:0] ram_wdata;
   logic               ram_re;
   logic [COUNT_W-1:0] ram_rdata;

   llh_ram #(
      .WIDTH (COUNT_W),
      .DEPTH (HIST_DEPTH)
   ) u_bins (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (addr_ff),
      .rd_data (ram_rdata)
   );

   // ---------------------------------------------------------------------
   // decode of the request beat
   // ---------------------------------------------------------------------
   logic               req_take;
   logic [EXP_W-1:0]   lum_exp;
   logic               lum_ok;
   logic [IDX_W-1:0]   idx_ext;
   logic               idx_in_range;
   logic               last_sweep;
   logic               rsp_free;

   assign req_take = req_valid && (state_ff == ST_IDLE);
   assign lum_exp  = req_luminance[30:23];
   // sign set, Inf/NaN, below min, at or above max are dropped
   assign lum_ok   = !req_luminance[31] && (lum_exp != EXP_SPECIAL) &&
                     (req_luminance[30:0] >= lum_min_ff) &&
                     (req_luminance[30:0] < lum_max_ff);
   assign idx_ext  = IDX_W'(req_bin_index);
   assign idx_in_range = (32'(req_bin_index) < 32'(HIST_DEPTH));
   assign last_sweep = (sweep_ff == BIN_W'(HIST_DEPTH - 1));
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;

   // ---------------------------------------------------------------------
   // next state
   // ---------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (last_sweep) begin
               state_in = reply_ff ? ST_REPLY : ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               case (llh_cmd_type'(req_cmd))
                  CMD_ADD:   state_in = lum_ok ? ST_LOG : ST_REPLY;
                  CMD_READ:  state_in = idx_in_range ? ST_FETCH : ST_REPLY;
                  CMD_CLEAR: state_in = ST_CLEAR;
                  default:   state_in = ST_REPLY;
               endcase
            end
         end
         ST_LOG: begin
            if (k_ff == '0) begin
               state_in = ST_SCALE;
            end
         end
         ST_SCALE:  state_in = ST_MULT;
         ST_MULT:   state_in = ST_CLAMP;
         ST_CLAMP:  state_in = ST_FETCH;
         ST_FETCH:  state_in = ST_UPDATE;
         ST_UPDATE: state_in = ST_REPLY;
         ST_REPLY: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default:   state_in = ST_IDLE;
      endcase
   end

   // ---------------------------------------------------------------------
   // datapath and outputs
   // ---------------------------------------------------------------------
   logic [PROD_SQ_W-1:0]  sq_prod;
   logic [SQ_W:0]         sq_val;      // Q2.30
   logic [LOG_W:0]        log_diff;
   logic [PROD_BIN_W-1:0] bin_prod;
   logic [LOG_W-1:0]      used_lim;
   logic [LOG_W-1:0]      bin_sel;
   logic [LOG_W-1:0]      bc_ext;
   logic [LOG_W-1:0]      depth_ext;
   logic [COUNT_W-1:0]    bin_next;

   assign sq_prod  = PROD_SQ_W'(x_ff) * PROD_SQ_W'(x_ff);
   assign sq_val   = sq_prod[PROD_SQ_W-1 -: SQ_W+1];
   assign log_diff = {e_ff[EXP_W-1], e_ff, r_ff} -
                     {log_floor_ff[LOG_W-1], log_floor_ff};
   assign bin_prod = PROD_BIN_W'(d_ff) * PROD_BIN_W'(bin_scale_ff);

   // bins in use: zero acts as one, clipped to the RAM depth
   assign bc_ext    = LOG_W'(bin_count_ff);
   assign depth_ext = LOG_W'(HIST_DEPTH);
   assign used_lim  = (bin_count_ff == '0) ? '0 :
                      ((bc_ext > depth_ext) ? depth_ext - LOG_W'(1) : bc_ext - LOG_W'(1));
   assign bin_sel   = (bin_raw_ff > used_lim) ? used_lim : bin_raw_ff;
   assign bin_next  = sat_inc(ram_rdata);

   always_comb begin
      sweep_in       = sweep_ff;
      reply_in       = reply_ff;
      op_in          = op_ff;
      x_in           = x_ff;
      k_in           = k_ff;
      e_in           = e_ff;
      r_in           = r_ff;
      d_in           = d_ff;
      bin_raw_in     = bin_raw_ff;
      addr_in        = addr_ff;
      total_in       = total_ff;
      res_counted_in = res_counted_ff;
      res_hit_in     = res_hit_ff;
      res_value_in   = res_value_ff;
      rsp_counted_in = rsp_counted_ff;
      rsp_hit_in     = rsp_hit_ff;
      rsp_value_in   = rsp_value_ff;
      rsp_total_in   = rsp_total_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      ram_we         = 1'b0;
      ram_waddr      = addr_ff;
      ram_wdata      = bin_next;
      ram_re         = 1'b0;
      req_stall      = (state_ff != ST_IDLE);

      case (state_ff)
         ST_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = sweep_ff;
            ram_wdata = '0;
            sweep_in  = sweep_ff + BIN_W'(1);
         end
         ST_IDLE: begin
            if (req_take) begin
               res_counted_in = 1'b0;
               res_hit_in     = '0;
               res_value_in   = '0;
               op_in          = llh_cmd_type'(req_cmd);
               case (llh_cmd_type'(req_cmd))
                  CMD_ADD: begin
                     // 1.mant in Q1.30 from the top mantissa bits
                     x_in = {1'b1, req_luminance[22 -: LOG_TABLE_BITS],
                             {(SQ_W-1-LOG_TABLE_BITS){1'b0}}};
                     k_in = STEP_W'(LOG_FRAC_W - 1);
                     e_in = lum_exp - EXP_BIAS;    // exponent 0 gives -127 too
                     r_in = '0;
                  end
                  CMD_READ: begin
                     res_hit_in = req_bin_index;
                     addr_in    = idx_ext[BIN_W-1:0];
                  end
                  CMD_CLEAR: begin
                     total_in = '0;
                     sweep_in = '0;
                     reply_in = 1'b1;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_LOG: begin
            // one result bit per squaring round
            r_in[k_ff] = sq_val[SQ_W];
            x_in       = sq_val[SQ_W] ? sq_val[SQ_W:1] : sq_val[SQ_W-1:0];
            k_in       = k_ff - STEP_W'(1);
         end
         ST_SCALE: begin
            d_in = (!log_diff[LOG_W] && (log_diff != '0)) ? log_diff[LOG_W-1:0] : '0;
         end
         ST_MULT: begin
            bin_raw_in = bin_prod[PROD_BIN_W-1 -: LOG_W];
         end
         ST_CLAMP: begin
            addr_in    = bin_sel[BIN_W-1:0];
            res_hit_in = bin_sel[HIT_W-1:0];
         end
         ST_FETCH: begin
            ram_re = 1'b1;
         end
         ST_UPDATE: begin
            if (op_ff == CMD_ADD) begin
               ram_we         = 1'b1;
               total_in       = sat_inc(total_ff);
               res_counted_in = 1'b1;
               res_value_in   = bin_next;
            end else begin
               res_value_in   = ram_rdata;
            end
         end
         ST_REPLY: begin
            if (rsp_free) begin
               rsp_valid_in   = 1'b1;
               rsp_counted_in = res_counted_ff;
               rsp_hit_in     = res_hit_ff;
               rsp_value_in   = res_value_ff;
               rsp_total_in   = total_ff;
               reply_in       = 1'b0;
            end
         end
         default: begin
         end
      endcase
   end

   // ---------------------------------------------------------------------
   // control registers
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         sweep_ff     <= '0;
         reply_ff     <= 1'b0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         lum_min_ff   <= LUM_MIN_RST;
         lum_max_ff   <= LUM_MAX_RST;
         log_floor_ff <= LOG_FLOOR_RST;
         bin_scale_ff <= BIN_SCALE_RST;
         bin_count_ff <= BIN_COUNT_RST;
      end else begin
         state_ff     <= state_in;
         sweep_ff     <= sweep_in;
         reply_ff     <= reply_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            case (csr_index)
               CSR_LUM_MIN:   lum_min_ff   <= csr_wdata[BOUND_W-1:0];
               CSR_LUM_MAX:   lum_max_ff   <= csr_wdata[BOUND_W-1:0];
               CSR_LOG_FLOOR: log_floor_ff <= csr_wdata[LOG_W-1:0];
               CSR_BIN_SCALE: bin_scale_ff <= csr_wdata[SCALE_W-1:0];
               CSR_BIN_COUNT: bin_count_ff <= csr_wdata[BINCNT_W-1:0];
               default: begin
               end
            endcase
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      op_ff          <= op_in;
      x_ff           <= x_in;
      k_ff           <= k_in;
      e_ff           <= e_in;
      r_ff           <= r_in;
      d_ff           <= d_in;
      bin_raw_ff     <= bin_raw_in;
      addr_ff        <= addr_in;
      res_counted_ff <= res_counted_in;
      res_hit_ff     <= res_hit_in;
      res_value_ff   <= res_value_in;
      rsp_counted_ff <= rsp_counted_in;
      rsp_hit_ff     <= rsp_hit_in;
      rsp_value_ff   <= rsp_value_in;
      rsp_total_ff   <= rsp_total_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_counted     = rsp_counted_ff;
   assign rsp_bin_hit     = rsp_hit_ff;
   assign rsp_bin_value   = rsp_value_ff;
   assign rsp_total_count = rsp_total_ff;

   // ---------------------------------------------------------------------
   // assertions
   // ---------------------------------------------------------------------
`ifndef NO_ASSERTIONS
   a_total_step: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && (total_ff != $past(total_ff))) |->
         ((total_ff == $past(total_ff) + COUNT_W'(1)) || (total_ff == '0)))
      else $error("total counter moved by more than one");

   a_counted_total: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_counted) |-> (rsp_total_count != '0))
      else $error("counted beat with zero total");

   a_counted_value: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_counted) |-> (rsp_bin_value != '0))
      else $error("counted beat with empty bin");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && $rose(rsp_valid)) |-> ($past(state_ff) == ST_REPLY))
      else $error("response raised outside reply");

   a_ram_addr: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (32'(ram_waddr) < 32'(HIST_DEPTH)))
      else $error("bin write beyond depth");
`endif

endmodule

// ----- hdl/llh_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// llh_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module llh_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      // read data holds while rd_en is low
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
